@@ hw/rtl/uwm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package uwm_pkg;

  localparam int BYTE_W      = 8;
  localparam int PLEN_W      = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int PAT_REGS    = 6;
  localparam int PAT_BYTES   = PAT_REGS * CFG_DATA_W / BYTE_W;

  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS_0_7 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS_LAST = 3'd6;

  // beat travelling down the cell chain, one DP row skewed by one column per cell
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] url_byte;
    logic              last;
    logic              kill;   // star cells still inside the hostname on a '/' row
    logic              left;   // this row, previous column
    logic              diag;   // previous row, previous column
    logic              res;    // final-column value once passed
  } cell_bus_t;

endpackage

`default_nettype wire

@@ hw/rtl/uwm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface uwm_in_if;
  logic                         valid;
  logic                         ready;
  logic [uwm_pkg::BYTE_W-1:0]   url_byte;
  logic                         url_last;
  modport source (output valid, output url_byte, output url_last, input ready);
  modport sink   (input valid, input url_byte, input url_last, output ready);
endinterface

interface uwm_out_if;
  logic valid;
  logic ready;
  logic matched;
  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

interface uwm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [uwm_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [uwm_pkg::CFG_DATA_W-1:0]   wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/uwm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module uwm_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic [uwm_pkg::BYTE_W-1:0] pat_byte,
  input  wire logic                       col_en,
  input  wire logic                       col_tail,
  input  wire logic                       seed_en,
  input  wire uwm_pkg::cell_bus_t         bus_i,
  output uwm_pkg::cell_bus_t              bus_o
);

  import uwm_pkg::*;

  logic      above_r;
  logic      above_nxt;
  cell_bus_t bus_r;
  cell_bus_t bus_nxt;

  logic hit;
  logic above;
  logic cell_bit;

  always_comb begin
    hit   = (bus_i.url_byte == pat_byte);
    // leading star: row zero carries a one in column one
    above = above_r | (seed_en & bus_i.diag & (pat_byte == CH_STAR));
    if (hit) begin
      cell_bit = bus_i.diag;
    end else if (pat_byte == CH_STAR) begin
      cell_bit = ~bus_i.kill & (bus_i.left | above);
    end else begin
      cell_bit = 1'b0;
    end
    cell_bit = cell_bit & col_en;

    bus_nxt          = bus_i;
    bus_nxt.kill     = bus_i.kill & ~(hit & (bus_i.url_byte == CH_SLASH));
    bus_nxt.left     = cell_bit;
    bus_nxt.diag     = above & col_en;
    bus_nxt.res      = col_tail ? cell_bit : bus_i.res;

    above_nxt = bus_i.last ? 1'b0 : cell_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r     <= 1'b0;
      bus_r.valid <= 1'b0;
    end else if (adv) begin
      bus_r.valid <= bus_nxt.valid;
      if (bus_i.valid) begin
        above_r <= above_nxt;
      end
    end
    if (adv) begin
      bus_r.url_byte <= bus_nxt.url_byte;
      bus_r.last     <= bus_nxt.last;
      bus_r.kill     <= bus_nxt.kill;
      bus_r.left     <= bus_nxt.left;
      bus_r.diag     <= bus_nxt.diag;
      bus_r.res      <= bus_nxt.res;
    end
  end

  assign bus_o = bus_r;

endmodule

`default_nettype wire

@@ hw/rtl/url_wildcard_matcher.sv @@
// Wildcard URL matcher: URL bytes stream in one beat per cycle and run down a chain of
// PATTERN_MAX cells, one per pattern column, each registering its column of the DP row
// from its left neighbor's output. A beat flagged url_last produces one result beat
// (matched) once it has passed every cell and the result register; other beats produce
// nothing. Throughput is one byte per cycle, since the chain is fully pipelined; the
// whole chain holds while a result beat waits on out_bus.ready, and in_bus.ready is
// low after each configuration write while the pattern's slash flag
// is recomputed. cfg_bus.ready is always high. The user must write configuration with
// no bytes in the chain; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module url_wildcard_matcher #(
  parameter int PATTERN_MAX = 48
) (
  input wire logic clk,
  input wire logic rst_n,
  uwm_in_if.sink   in_bus,
  uwm_out_if.source out_bus,
  uwm_cfg_if.sink  cfg_bus
);

  import uwm_pkg::*;

  logic [PLEN_W-1:0]     plen_r;
  logic [CFG_DATA_W-1:0] pat_words_r [PAT_REGS];
  logic                  has_slash_r;
  logic                  has_slash_nxt;
  logic                  cfg_pend_r;
  logic                  first_r;
  logic                  host_seen_r;
  logic                  out_valid_r;
  logic                  out_matched_r;

  logic [PLEN_W-1:0]     plen_used;
  logic                  adv;
  logic                  in_acc;
  logic                  cfg_acc;
  logic [PATTERN_MAX-1:0] col_en;
  logic [PATTERN_MAX-1:0] col_tail;
  logic [BYTE_W-1:0]      col_byte [PATTERN_MAX];
  cell_bus_t              chain [PATTERN_MAX+1];

  assign cfg_bus.ready = 1'b1;
  assign cfg_acc       = cfg_bus.valid & cfg_bus.ready;
  assign adv           = ~out_valid_r | out_bus.ready;
  assign in_bus.ready  = adv & ~cfg_pend_r;
  assign in_acc        = in_bus.valid & in_bus.ready;

  assign plen_used = (plen_r > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX) : plen_r;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r     <= '0;
      for (int i = 0; i < PAT_REGS; i++) begin
        pat_words_r[i] <= '0;
      end
      cfg_pend_r  <= 1'b0;
      has_slash_r <= 1'b0;
    end else begin
      cfg_pend_r  <= cfg_acc;
      has_slash_r <= has_slash_nxt;
      if (cfg_acc) begin
        if (cfg_bus.reg_index == CFG_PATTERN_LENGTH) begin
          plen_r <= cfg_bus.wdata[PLEN_W-1:0];
        end else if (cfg_bus.reg_index >= CFG_PATTERN_CHARS_0_7 &&
                     cfg_bus.reg_index <= CFG_PATTERN_CHARS_LAST) begin
          pat_words_r[cfg_bus.reg_index - CFG_PATTERN_CHARS_0_7] <= cfg_bus.wdata;
        end
      end
    end
  end

  // per-column pattern byte and enables
  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_col
    if (g < PAT_BYTES) begin : g_byte
      assign col_byte[g] = pat_words_r[g / 8][(g % 8) * BYTE_W +: BYTE_W];
    end else begin : g_zero
      assign col_byte[g] = '0;
    end
    assign col_en[g]   = (PLEN_W'(g + 1) <= plen_used);
    assign col_tail[g] = (PLEN_W'(g + 1) == plen_used);
  end

  // does the active pattern contain a '/'; a '/' row then ends the hostname
  always_comb begin
    has_slash_nxt = 1'b0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      has_slash_nxt = has_slash_nxt | (col_en[i] & (col_byte[i] == CH_SLASH));
    end
  end

  // ---- URL-level state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= 1'b1;
      host_seen_r <= 1'b0;
    end else if (in_acc) begin
      if (in_bus.url_last) begin
        first_r     <= 1'b1;
        host_seen_r <= 1'b0;
      end else begin
        first_r     <= 1'b0;
        host_seen_r <= host_seen_r | ((in_bus.url_byte == CH_SLASH) & has_slash_r);
      end
    end
  end

  assign chain[0].valid    = in_acc;
  assign chain[0].url_byte = in_bus.url_byte;
  assign chain[0].last     = in_bus.url_last;
  assign chain[0].kill     = ~host_seen_r & (in_bus.url_byte == CH_SLASH);
  assign chain[0].left     = 1'b0;
  assign chain[0].diag     = first_r;
  assign chain[0].res      = 1'b0;

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    uwm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .pat_byte (col_byte[g]),
      .col_en   (col_en[g]),
      .col_tail (col_tail[g]),
      .seed_en  (g == 0),
      .bus_i    (chain[g]),
      .bus_o    (chain[g+1])
    );
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[PATTERN_MAX].valid & chain[PATTERN_MAX].last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_matched_r <= chain[PATTERN_MAX].res;
    end
  end

  assign out_bus.valid   = out_valid_r;
  assign out_bus.matched = out_matched_r;

  // ---- assertions ----
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> !in_bus.ready)
    else $error("input accepted right after a config write");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_bus.url_last) |=> (first_r && !host_seen_r))
    else $error("URL state not restored after last beat");

  a_host_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_bus.url_last && in_bus.url_byte != CH_SLASH)
      |=> (host_seen_r == $past(host_seen_r)))
    else $error("hostname flag moved on a non-slash byte");

  a_result_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && chain[PATTERN_MAX].valid && chain[PATTERN_MAX].last)
      |=> (out_valid_r && out_matched_r == $past(chain[PATTERN_MAX].res)))
    else $error("chain tail result not captured");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !(chain[PATTERN_MAX].valid && chain[PATTERN_MAX].last)) |=> !out_valid_r)
    else $error("result beat without a last byte");

endmodule

`default_nettype wire

@@ sim/url_wildcard_matcher_test.sv @@
`timescale 1ns / 1ps

module url_wildcard_matcher_test;
  import uwm_pkg::*;

  localparam int PMAX = 48;
  localparam int LIMIT_CYCLES = 400000;
  localparam int TARGET_BYTES = 1800;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = CFG_PATTERN_CHARS_LAST + 3'd1;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [BYTE_W-1:0]     ch;
    logic                  is_last;
    bit                    typed;
    bit                    want;
  } dir_row_t;

  localparam int DIR_ROWS = 28;

  // typed expectations only where the answer is obvious; others go through the predictor
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_BYTE, CFG_PATTERN_LENGTH, 64'h0, 8'h61, 1'b1, 1'b1, 1'b0},  // empty pattern
    '{ROW_CFG, CFG_PATTERN_LENGTH, 64'd1, 8'h0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, CFG_PATTERN_CHARS_0_7, 64'h2A, 8'h0, 1'b0, 1'b0, 1'b0},
    '{ROW_BYTE, CFG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b1, 1'b1, 1'b1},
    '{ROW_BYTE, CFG_PATTERN_LENGTH, 64'h0, 8'hFF, 1'b1, 1'b1, 1'b1},
    '{ROW_BYTE, CFG_PATTERN_LENGTH, 64'h0, 8'h2F, 1'b1, 1'b1, 1'b0},  // '/' in hostname
    '{ROW_BYTE, CFG_PATTERN_LENGTH, 64'h0, 8'h2A, 1'b1, 1'b1, 1'b1},  // literal '*'
    '{ROW_CFG, CFG_PATTERN_LENGTH, 64'd3, 8'h0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, CFG_PATTERN_CHARS_0_7, 64'h2A2F61, 8'h0, 1'b0, 1'b0, 1'b0},  // "a/*"
    '{ROW_BYTE, CFG_PATTERN_LENGTH, 64'h0, 8'h61, 1'b0, 1'b0, 1'b0},
    '{ROW_BYTE, CFG_PATTERN_LENGTH, 64'h0, 8'h2F, 1'b0, 1'b0, 1'b0},
    '{ROW_BYTE, CFG_PATTERN_LENGTH, 64'h0, 8'h78, 1'b0, 1'b0, 1'b0},
    '{ROW_BYTE, CFG_PATTERN_LENGTH, 64'h0, 8'h2F, 1'b0, 1'b0, 1'b0},
    '{ROW_BYTE, CFG_PATTERN_LENGTH, 64'h0, 8'h79, 1'b1, 1'b0, 1'b0},
    '{ROW_CFG, CFG_PATTERN_LENGTH, 64'd63, 8'h0, 1'b0, 1'b0, 1'b0},  // saturates
    '{ROW_CFG, CFG_PATTERN_CHARS_0_7, {8{8'h2A}}, 8'h0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, CFG_PATTERN_CHARS_0_7 + 3'd1, {8{8'h2A}}, 8'h0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, CFG_PATTERN_CHARS_0_7 + 3'd2, {8{8'h2A}}, 8'h0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, CFG_PATTERN_CHARS_0_7 + 3'd3, {8{8'h2A}}, 8'h0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, CFG_PATTERN_CHARS_0_7 + 3'd4, {8{8'h2A}}, 8'h0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, CFG_PATTERN_CHARS_LAST, {8{8'h2A}}, 8'h0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, CFG_NO_REG, {64{1'b1}}, 8'h0, 1'b0, 1'b0, 1'b0},  // no such register
    '{ROW_BYTE, CFG_PATTERN_LENGTH, 64'h0, 8'h61, 1'b1, 1'b1, 1'b1},
    '{ROW_CFG, CFG_PATTERN_LENGTH, 64'd2, 8'h0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, CFG_PATTERN_CHARS_0_7, 64'h6261, 8'h0, 1'b0, 1'b0, 1'b0},  // "ab"
    '{ROW_BYTE, CFG_PATTERN_LENGTH, 64'h0, 8'h61, 1'b0, 1'b0, 1'b0},
    // rewritten between the two bytes of one URL
    '{ROW_CFG, CFG_PATTERN_CHARS_0_7, 64'h6278, 8'h0, 1'b0, 1'b0, 1'b0},  // "xb"
    '{ROW_BYTE, CFG_PATTERN_LENGTH, 64'h0, 8'h62, 1'b1, 1'b0, 1'b0}
  };

  logic clk;
  logic rst_n;

  uwm_in_if  in_if ();
  uwm_out_if out_if ();
  uwm_cfg_if cfg_if ();

  url_wildcard_matcher #(.PATTERN_MAX(PMAX)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  // predictor state
  logic [PLEN_W-1:0]           pm_len;
  logic [PAT_BYTES*BYTE_W-1:0] pm_pattern;
  logic [PMAX:0]               pm_row;
  bit                          pm_past_host;

  bit pending_match_q [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          cycle_count;
  int          bad_count;
  int          bytes_sent;
  int          urls_checked;
  int          hits_seen;
  int          settings_used;
  logic [7:0]  regs_written;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_match_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_match_q.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: result beat matched=%b with nothing expected", $realtime,
                   out_if.matched);
      end else begin
        bit want;
        want = pending_match_q.pop_front();
        urls_checked++;
        if (out_if.matched === 1'b1) hits_seen++;
        if (out_if.matched !== want) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: matched mismatch, expected %b got %b", $realtime, want,
                     out_if.matched);
        end
      end
    end
  end

  function automatic logic [BYTE_W-1:0] pm_char(input int idx);
    if (idx >= PAT_BYTES) return '0;
    return pm_pattern[idx*BYTE_W +: BYTE_W];
  endfunction

  // one DP row per URL byte; returns the final column on the last byte
  function automatic void match_step(input logic [BYTE_W-1:0] c, input logic is_last,
                                     output bit has_res, output bit res);
    int            plen;
    logic [PMAX:0] prev;
    logic [PMAX:0] cur;
    bit            in_host;
    logic [BYTE_W-1:0] p;
    plen = (pm_len > PMAX) ? PMAX : int'(pm_len);
    prev = pm_row;
    cur = '0;
    in_host = !pm_past_host;
    if (prev[0] && plen >= 1 && pm_char(0) == CH_STAR) prev[1] = 1'b1;
    for (int j = 1; j <= plen; j++) begin
      p = pm_char(j - 1);
      if (c == p) begin
        cur[j] = prev[j-1];
        if (in_host && c == CH_SLASH) in_host = 1'b0;
      end else if (p == CH_STAR) begin
        if (!(in_host && c == CH_SLASH)) cur[j] = cur[j-1] | prev[j];
      end
    end
    has_res = is_last;
    res = cur[plen];
    if (is_last) begin
      pm_row = (PMAX+1)'(1);
      pm_past_host = 1'b0;
    end else begin
      pm_row = cur;
      pm_past_host = !in_host;
    end
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] ch, input logic is_last,
                           input bit typed, input bit want);
    bit has_res;
    bit res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.url_byte <= ch;
    in_if.url_last <= is_last;
    do @(posedge clk); while (!in_if.ready);
    match_step(ch, is_last, has_res, res);
    if (has_res) pending_match_q.push_back(typed ? want : res);
    bytes_sent++;
  endtask

  // leaves cfg valid high so back-to-back writes never drop it; caller lowers it
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    do @(posedge clk); while (!cfg_if.ready);
    regs_written[idx] = 1'b1;
    if (idx == CFG_PATTERN_LENGTH)
      pm_len = data[PLEN_W-1:0];
    else if (idx >= CFG_PATTERN_CHARS_0_7 && idx <= CFG_PATTERN_CHARS_LAST)
      pm_pattern[(idx - CFG_PATTERN_CHARS_0_7)*CFG_DATA_W +: CFG_DATA_W] = data;
  endtask

  // beats without a result may still be in the cell chain after the queue empties
  task automatic drain_chain();
    in_if.valid <= 1'b0;
    while (pending_match_q.size() != 0) @(posedge clk);
    repeat (PMAX + 4) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_pat_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 22) return CH_STAR;
    if (r < 34) return CH_SLASH;
    if (r < 44) return 8'h2E;
    if (r < 90) return 8'h61 + BYTE_W'($urandom_range(3));
    return BYTE_W'($urandom_range(255));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_url_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return CH_SLASH;
    if (r < 25) return 8'h2E;
    if (r < 30) return CH_STAR;
    if (r < 90) return 8'h61 + BYTE_W'($urandom_range(3));
    return BYTE_W'($urandom_range(255));
  endfunction

  initial begin
    logic [PAT_BYTES*BYTE_W-1:0] new_pat;
    logic [BYTE_W-1:0]           url [$];
    logic [PLEN_W-1:0]           new_len;
    bit                          in_cfg;
    int                          eff_len;
    int                          budget;
    int                          phase_start;
    int                          pos;
    int                          ph;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.url_byte = '0;
    in_if.url_last = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = CFG_PATTERN_LENGTH;
    cfg_if.wdata = '0;
    out_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cycle_count = 0;
    bad_count = 0;
    bytes_sent = 0;
    urls_checked = 0;
    hits_seen = 0;
    settings_used = 0;
    regs_written = '0;
    pm_len = '0;
    pm_pattern = '0;
    pm_row = (PMAX+1)'(1);
    pm_past_host = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_cfg = 1'b0;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!in_cfg) drain_chain();
        cfg_write(dir_rows[i].idx, dir_rows[i].data);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) cfg_if.valid <= 1'b0;
        in_cfg = 1'b0;
        send_byte(dir_rows[i].ch, dir_rows[i].is_last, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    ph = 0;
    while (bytes_sent < TARGET_BYTES) begin
      drain_chain();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase

      for (int k = 0; k < PAT_BYTES; k++) new_pat[k*BYTE_W +: BYTE_W] = pick_pat_char();
      case (ph)
        0: new_len = '0;
        1: begin
          new_len = PLEN_W'(PMAX);
          new_pat = '1;
        end
        2: new_len = '1;
        3: new_len = PLEN_W'(PMAX);
        default: new_len = PLEN_W'($urandom_range(14, 1));
      endcase
      cfg_write(CFG_PATTERN_LENGTH, CFG_DATA_W'(new_len));
      for (int k = 0; k < PAT_REGS; k++)
        cfg_write(CFG_PATTERN_CHARS_0_7 + CFG_IDX_W'(k), new_pat[k*CFG_DATA_W +: CFG_DATA_W]);
      if ($urandom_range(3) == 0) cfg_write(CFG_NO_REG, {$urandom, $urandom});
      cfg_if.valid <= 1'b0;
      settings_used++;

      eff_len = (new_len > PMAX) ? PMAX : int'(new_len);
      budget = (ph == 0) ? 30 : 150;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < budget) begin
        url.delete();
        if ($urandom_range(9) < 7) begin
          // walk the pattern, expanding stars into short runs
          for (int j = 0; j < eff_len; j++) begin
            if (new_pat[j*BYTE_W +: BYTE_W] == CH_STAR) begin
              repeat ($urandom_range(3)) url.push_back(pick_url_char());
            end else begin
              url.push_back(new_pat[j*BYTE_W +: BYTE_W]);
            end
          end
          if (url.size() > 0 && $urandom_range(9) < 4) begin
            pos = $urandom_range(url.size() - 1);
            case ($urandom_range(2))
              0: url[pos] = pick_url_char();
              1: url.delete(pos);
              default: url.insert(pos, pick_url_char());
            endcase
          end
        end else begin
          repeat ($urandom_range(10, 1))
            url.push_back($urandom_range(1) ? pick_url_char() : BYTE_W'($urandom_range(255)));
        end
        if (url.size() == 0) url.push_back(pick_url_char());
        foreach (url[j]) send_byte(url[j], j == url.size() - 1, 1'b0, 1'b0);
      end
      ph++;
    end

    in_if.valid <= 1'b0;
    while (pending_match_q.size() != 0) @(posedge clk);
    repeat (PMAX + 8) @(posedge clk);

    if (pending_match_q.size() != 0) begin
      bad_count += pending_match_q.size();
      $display("%0d expected results never arrived", pending_match_q.size());
    end

    $display("Streamed %0d URL bytes under %0d pattern settings (registers touched %b)",
             bytes_sent, settings_used, regs_written);
    $display("Checked %0d URL results, %0d of them matches; %0d mismatches",
             urls_checked, hits_seen, bad_count);
    if (bad_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/uwm_pkg.sv
hw/rtl/uwm_if.sv
hw/rtl/uwm_cell.sv
hw/rtl/url_wildcard_matcher.sv
sim/url_wildcard_matcher_test.sv
